[hw/rtl/multitrack_audio_looper_defines.svh]
// Assertion macros for the looper RTL.
// Used by the top level only; no other dependencies.
`ifndef MULTITRACK_AUDIO_LOOPER_DEFINES_SVH
`define MULTITRACK_AUDIO_LOOPER_DEFINES_SVH
// Check a property on the rising clock edge, disabled in reset.
`define MAL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on the rising clock edge, also in reset.
`define MAL_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[hw/rtl/mal_pkg.sv]
// Package for the multitrack audio looper: constants, types, helpers.
// No dependencies.
package mal_pkg;
    localparam int TRACK_COUNT = 4;
    localparam int BUFFER_FRAMES = 65536;
    localparam int TW = 2;
    localparam int AW = 16;
    localparam int LW = 17;

    localparam logic [2:0] OP_FRAME = 3'd0;
    localparam logic [2:0] OP_ACTION = 3'd1;
    localparam logic [2:0] OP_CLEAR = 3'd2;
    localparam logic [2:0] OP_TOGGLE = 3'd3;
    localparam logic [2:0] OP_LEVEL = 3'd4;

    localparam logic [2:0] MODE_EMPTY = 3'd0;
    localparam logic [2:0] MODE_ARMED = 3'd1;
    localparam logic [2:0] MODE_REC = 3'd2;
    localparam logic [2:0] MODE_PLAY = 3'd3;
    localparam logic [2:0] MODE_STOP = 3'd4;

    localparam logic [1:0] CFG_SYNC = 2'd0;
    localparam logic [1:0] CFG_BARS = 2'd1;
    localparam logic [1:0] CFG_MON = 2'd2;

    localparam logic [LW-1:0] FULL_LEN = LW'(BUFFER_FRAMES);

    typedef struct packed {
        logic [2:0] opcode;
        logic [1:0] track;
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
        logic bar_pulse;
        logic clock_locked;
        logic [16:0] quarter_period;
        logic [7:0] level;
        logic [11:0] pan;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic [2:0] track_state;
        logic [16:0] track_length;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic signed [15:0] sample;
        logic [7:0] gain;
        logic [11:0] bal;
    } mac_cmd_t;

    function automatic logic signed [17:0] sat16(input logic signed [19:0] v);
        logic signed [17:0] r;
        begin
            if (v > 20'sd32767) r = 18'sd32767;
            else if (v < -20'sd32768) r = -18'sd32768;
            else r = v[17:0];
            return r;
        end
    endfunction
endpackage

[hw/rtl/mal_stream_if.sv]
// Valid/ready channel interface for the looper.
// Depends on nothing; payload type is a parameter of the instance.
interface mal_stream_if #(parameter type payload_t = logic) ();
    logic valid;
    logic ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/mal_mac.sv]
// Shared gain and pan unit: one multiply per cycle, for gain, then left and right balance.
// Depends on mal_pkg.
module mal_mac (
    input  logic clk,
    input  logic rst_n,
    input  mal_pkg::mac_cmd_t cmd,
    output logic done,
    output logic signed [19:0] left_term,
    output logic signed [19:0] right_term
);
    import mal_pkg::*;

    logic [1:0] step_reg, step_next;
    logic busy_reg, busy_next;
    logic signed [15:0] s_reg, s_next;
    logic [11:0] bal_reg, bal_next;
    logic [7:0] gain_reg, gain_next;
    logic signed [31:0] prod_reg, prod_next;
    logic signed [19:0] l_reg, l_next, r_reg, r_next;
    logic signed [17:0] ma;
    logic signed [13:0] mb;
    logic signed [31:0] mp;

    always_comb
    begin
        ma = 18'(s_reg);
        mb = 14'(signed'({1'b0, gain_reg}));
        unique case (step_reg)
            2'd0:
            begin
                ma = 18'(s_reg);
                mb = 14'(signed'({1'b0, gain_reg}));
            end
            2'd1:
            begin
                ma = prod_reg[25:8];
                mb = 14'(signed'({1'b0, 12'(12'd4095 - bal_reg)}));
            end
            2'd2:
            begin
                ma = prod_reg[25:8];
                mb = 14'(signed'({1'b0, bal_reg}));
            end
            default:
            begin
                ma = 18'sd0;
                mb = 14'sd0;
            end
        endcase
        mp = 32'(ma * mb);
    end

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        s_next = s_reg;
        bal_next = bal_reg;
        gain_next = gain_reg;
        prod_next = prod_reg;
        l_next = l_reg;
        r_next = r_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            step_next = 2'd0;
            s_next = cmd.sample;
            gain_next = cmd.gain;
            bal_next = cmd.bal;
        end
        else if (busy_reg)
        begin
            unique case (step_reg)
                2'd0: prod_next = mp;
                2'd1: l_next = 20'(mp >>> 12);
                2'd2:
                begin
                    r_next = 20'(mp >>> 12);
                    busy_next = 1'b0;
                end
                default: busy_next = 1'b0;
            endcase
            step_next = step_reg + 2'd1;
        end
    end

    // The scaled sample is kept in prod_reg; slice then uses floor shift by 8.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        bal_reg <= bal_next;
        gain_reg <= gain_next;
        prod_reg <= prod_next;
        l_reg <= l_next;
        r_reg <= r_next;
    end

    assign done = busy_reg && (step_reg == 2'd2);
    assign left_term = l_reg;
    assign right_term = r_next;
endmodule

[hw/rtl/mal_store.sv]
// Sample memory for all tracks: one port, registered read.
// Depends on mal_pkg.
module mal_store (
    input  logic clk,
    input  logic we,
    input  logic re,
    input  logic [mal_pkg::TW+mal_pkg::AW-1:0] addr,
    input  logic signed [15:0] wdata,
    output logic signed [15:0] rdata
);
    import mal_pkg::*;

    logic signed [15:0] mem [TRACK_COUNT*BUFFER_FRAMES];

    always_ff @(posedge clk)
    begin
        if (we) mem[addr] <= wdata;
        if (re) rdata <= mem[addr];
    end
endmodule

[hw/rtl/multitrack_audio_looper.sv]
// Channel   | Dir | Payload
// in_ch     | in  | opcode, track, samples, clock info, level, pan
// out_ch    | out | left_out, right_out, track_state, track_length
// cfg       | in  | cfg_we, cfg_index, cfg_data
// A frame walks the tracks: S_TRK and S_MIX for an idle or recording track, S_TRK
// again when a take starts, S_RD and S_MAC too when playing (memory read, three
// multiplies on the shared unit), plus accept and result; a command has just those.
// A result waits in the output register; the next item is taken meanwhile and
// the sequencer holds in its result step until that register is free.
// Reset clears modes, lengths, positions; presets gain, pan, config; no memory pass.
// Top level of the looper; depends on mal_pkg, mal_stream_if, mal_store, mal_mac.
`include "multitrack_audio_looper_defines.svh"
module multitrack_audio_looper (
    input  logic clk,
    input  logic rst_n,
    mal_stream_if.sink in_ch,
    mal_stream_if.source out_ch,
    input  logic cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [4:0] cfg_data
);
    import mal_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TRK = 3'd1;
    localparam logic [2:0] S_RD = 3'd2;
    localparam logic [2:0] S_MAC = 3'd3;
    localparam logic [2:0] S_MIX = 3'd4;
    localparam logic [2:0] S_OUT = 3'd5;

    logic [2:0] st_reg, st_next;
    in_item_t it_reg, it_next;
    out_item_t res_reg, res_next;
    logic ov_reg, ov_next;
    logic [1:0] t_reg, t_next;
    logic signed [15:0] mono_reg, mono_next;
    logic signed [19:0] ml_reg, ml_next, mr_reg, mr_next;
    logic [2:0] mode_reg [TRACK_COUNT];
    logic [2:0] mode_next [TRACK_COUNT];
    logic [LW-1:0] len_reg [TRACK_COUNT];
    logic [LW-1:0] len_next [TRACK_COUNT];
    logic [LW-1:0] pos_reg [TRACK_COUNT];
    logic [LW-1:0] pos_next [TRACK_COUNT];
    logic [LW-1:0] tgt_reg [TRACK_COUNT];
    logic [LW-1:0] tgt_next [TRACK_COUNT];
    logic [7:0] gain_reg [TRACK_COUNT];
    logic [7:0] gain_next [TRACK_COUNT];
    logic [11:0] bal_reg [TRACK_COUNT];
    logic [11:0] bal_next [TRACK_COUNT];
    logic sync_reg, mon_reg;
    logic [4:0] bars_reg;
    logic [LW+6:0] tgt_prod_reg, tgt_prod_next;

    logic mem_we, mem_re;
    logic [TW+AW-1:0] mem_addr;
    logic signed [15:0] mem_rdata;
    mac_cmd_t mac_cmd;
    logic mac_done;
    logic signed [19:0] lt, rt;
    logic synced;
    logic [LW-1:0] tgt_val, p1;
    logic signed [16:0] sum17;

    mal_store u_store (
        .clk(clk), .we(mem_we), .re(mem_re), .addr(mem_addr),
        .wdata(mono_reg), .rdata(mem_rdata)
    );

    mal_mac u_mac (
        .clk(clk), .rst_n(rst_n), .cmd(mac_cmd), .done(mac_done),
        .left_term(lt), .right_term(rt)
    );

    assign in_ch.ready = (st_reg == S_IDLE);
    assign out_ch.valid = ov_reg;
    assign out_ch.data = res_reg;
    assign synced = sync_reg && it_reg.clock_locked;
    assign tgt_val = (!synced || tgt_prod_reg == '0 || tgt_prod_reg > (LW+7)'(BUFFER_FRAMES))
        ? FULL_LEN : tgt_prod_reg[LW-1:0];
    assign sum17 = 17'(in_ch.data.left_in) + 17'(in_ch.data.right_in);

    always_comb
    begin
        st_next = st_reg;
        it_next = it_reg;
        res_next = res_reg;
        ov_next = ov_reg;
        t_next = t_reg;
        mono_next = mono_reg;
        ml_next = ml_reg;
        mr_next = mr_reg;
        tgt_prod_next = tgt_prod_reg;
        mode_next = mode_reg;
        len_next = len_reg;
        pos_next = pos_reg;
        tgt_next = tgt_reg;
        gain_next = gain_reg;
        bal_next = bal_reg;
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_addr = {t_reg, pos_reg[t_reg][AW-1:0]};
        mac_cmd = '0;
        p1 = pos_reg[t_reg] + LW'(1);
        if (out_ch.valid && out_ch.ready) ov_next = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    it_next = in_ch.data;
                    mono_next = 16'(sum17 / 17'sd2);
                    ml_next = '0;
                    mr_next = '0;
                    t_next = '0;
                    tgt_prod_next = (LW+7)'(in_ch.data.quarter_period
                        * (bars_reg == '0 ? 5'd1 : bars_reg)) << 2;
                    st_next = (in_ch.data.opcode == OP_FRAME) ? S_TRK : S_OUT;
                end
            end
            S_TRK:
            begin
                if (mode_reg[t_reg] == MODE_ARMED && it_reg.bar_pulse)
                begin
                    mode_next[t_reg] = MODE_REC;
                    pos_next[t_reg] = '0;
                    len_next[t_reg] = '0;
                    tgt_next[t_reg] = tgt_val;
                    st_next = S_TRK;
                end
                else if (mode_reg[t_reg] == MODE_REC)
                begin
                    mem_we = !pos_reg[t_reg][AW];
                    if (p1 >= tgt_reg[t_reg])
                    begin
                        len_next[t_reg] = p1;
                        pos_next[t_reg] = '0;
                        mode_next[t_reg] = MODE_PLAY;
                    end
                    else pos_next[t_reg] = p1;
                    st_next = S_MIX;
                end
                else if (mode_reg[t_reg] == MODE_PLAY && len_reg[t_reg] != '0)
                begin
                    mem_re = 1'b1;
                    st_next = S_RD;
                end
                else st_next = S_MIX;
            end
            S_RD:
            begin
                mac_cmd.start = 1'b1;
                mac_cmd.sample = pos_reg[t_reg][AW] ? 16'sd0 : mem_rdata;
                mac_cmd.gain = gain_reg[t_reg];
                mac_cmd.bal = bal_reg[t_reg];
                pos_next[t_reg] = (p1 >= len_reg[t_reg]) ? '0 : p1;
                st_next = S_MAC;
            end
            S_MAC:
            begin
                if (mac_done)
                begin
                    ml_next = ml_reg + lt;
                    mr_next = mr_reg + rt;
                    st_next = S_MIX;
                end
            end
            S_MIX:
            begin
                t_next = t_reg + 2'd1;
                st_next = (t_reg == 2'(TRACK_COUNT-1)) ? S_OUT : S_TRK;
            end
            S_OUT:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    if (it_reg.opcode != OP_FRAME)
                    begin
                        unique case (it_reg.opcode)
                            OP_ACTION:
                            begin
                                unique case (mode_reg[it_reg.track])
                                    MODE_ARMED: mode_next[it_reg.track] = MODE_EMPTY;
                                    MODE_REC:
                                    begin
                                        len_next[it_reg.track] = pos_reg[it_reg.track];
                                        pos_next[it_reg.track] = '0;
                                        mode_next[it_reg.track] = MODE_PLAY;
                                    end
                                    MODE_PLAY: mode_next[it_reg.track] = MODE_STOP;
                                    default:
                                    begin
                                        len_next[it_reg.track] = '0;
                                        pos_next[it_reg.track] = '0;
                                        if (synced) mode_next[it_reg.track] = MODE_ARMED;
                                        else
                                        begin
                                            mode_next[it_reg.track] = MODE_REC;
                                            tgt_next[it_reg.track] = tgt_val;
                                        end
                                    end
                                endcase
                            end
                            OP_CLEAR:
                            begin
                                mode_next[it_reg.track] = MODE_EMPTY;
                                len_next[it_reg.track] = '0;
                                pos_next[it_reg.track] = '0;
                                tgt_next[it_reg.track] = '0;
                            end
                            OP_TOGGLE:
                            begin
                                if (mode_reg[it_reg.track] == MODE_PLAY)
                                    mode_next[it_reg.track] = MODE_STOP;
                                else if (len_reg[it_reg.track] != '0)
                                begin
                                    pos_next[it_reg.track] = '0;
                                    mode_next[it_reg.track] = MODE_PLAY;
                                end
                            end
                            OP_LEVEL:
                            begin
                                gain_next[it_reg.track] = it_reg.level;
                                bal_next[it_reg.track] = it_reg.pan;
                            end
                            default: ;
                        endcase
                        res_next.left_out = '0;
                        res_next.right_out = '0;
                    end
                    else
                    begin
                        res_next.left_out = 16'(sat16(ml_reg
                            + (mon_reg ? 20'(mono_reg) : 20'sd0)));
                        res_next.right_out = 16'(sat16(mr_reg
                            + (mon_reg ? 20'(mono_reg) : 20'sd0)));
                    end
                    res_next.track_state = mode_next[it_reg.track];
                    res_next.track_length = len_next[it_reg.track];
                    ov_next = 1'b1;
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
            sync_reg <= 1'b1;
            bars_reg <= 5'd4;
            mon_reg <= 1'b0;
            for (int i = 0; i < TRACK_COUNT; i++)
            begin
                mode_reg[i] <= MODE_EMPTY;
                len_reg[i] <= '0;
                pos_reg[i] <= '0;
                tgt_reg[i] <= '0;
                gain_reg[i] <= 8'd255;
                bal_reg[i] <= 12'd2048;
            end
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
            mode_reg <= mode_next;
            len_reg <= len_next;
            pos_reg <= pos_next;
            tgt_reg <= tgt_next;
            gain_reg <= gain_next;
            bal_reg <= bal_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_SYNC) sync_reg <= cfg_data[0];
                if (cfg_index == CFG_BARS) bars_reg <= cfg_data;
                if (cfg_index == CFG_MON) mon_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg <= it_next;
        res_reg <= res_next;
        t_reg <= t_next;
        mono_reg <= mono_next;
        ml_reg <= ml_next;
        mr_reg <= mr_next;
        tgt_prod_reg <= tgt_prod_next;
    end

    `MAL_ASSERT(a_no_take_busy, clk, rst_n, in_ch.valid && in_ch.ready |=> st_reg != S_IDLE, "input taken without work")
    `MAL_ASSERT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready |=> out_ch.valid, "result lost")
    `MAL_ASSERT(a_one_out, clk, rst_n, st_reg == S_OUT |=> out_ch.valid, "no result after item")
endmodule

[test/multitrack_audio_looper_tb.sv]
// Testbench for the four-track looper: drives frames and track commands over the
// input channel and checks each result against a behavioral predictor.
// Depends on mal_pkg, mal_stream_if and the multitrack_audio_looper RTL.
module multitrack_audio_looper_tb;
    import mal_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_SYNC;
    logic [4:0] cfg_data = '0;

    mal_stream_if #(.payload_t(in_item_t)) in_ch ();
    mal_stream_if #(.payload_t(out_item_t)) out_ch ();

    multitrack_audio_looper dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic signed [15:0] loop_mem [TRACK_COUNT][BUFFER_FRAMES];
    logic [2:0] mode_q [TRACK_COUNT];
    int unsigned len_q [TRACK_COUNT];
    int unsigned pos_q [TRACK_COUNT];
    int unsigned target_q [TRACK_COUNT];
    int unsigned gain_q [TRACK_COUNT];
    int unsigned bal_q [TRACK_COUNT];
    bit sync_q = 1'b1;
    int unsigned bars_q = 4;
    bit mon_q = 1'b0;

    out_item_t pending_results[$];
    int errors = 0;
    bit idle_off = 1'b0;
    int hold_cycles = 0;

    function automatic int floor_shr(input int v, input int n);
        return v >>> n;
    endfunction

    function automatic void start_take(input int t, input bit synced, input int unsigned qp);
        int unsigned b;
        longint unsigned tgt;
        b = (bars_q == 0) ? 1 : bars_q;
        tgt = synced ? longint'(qp) * 4 * b : 0;
        if (tgt == 0 || tgt > BUFFER_FRAMES) tgt = BUFFER_FRAMES;
        pos_q[t] = 0;
        len_q[t] = 0;
        target_q[t] = int'(tgt);
        mode_q[t] = MODE_REC;
    endfunction

    function automatic out_item_t predict_mix(input in_item_t it);
        out_item_t r;
        int ml, mr, mono, s, raw;
        int unsigned p;
        bit synced;
        int t;
        ml = 0;
        mr = 0;
        synced = sync_q && it.clock_locked;
        if (it.opcode == OP_FRAME) begin
            mono = (int'(it.left_in) + int'(it.right_in)) / 2;
            for (t = 0; t < TRACK_COUNT; t++) begin
                if (mode_q[t] == MODE_ARMED && it.bar_pulse)
                    start_take(t, synced, it.quarter_period);
                if (mode_q[t] == MODE_REC) begin
                    p = pos_q[t];
                    if (p < BUFFER_FRAMES) loop_mem[t][p] = 16'(mono);
                    p++;
                    if (p >= target_q[t]) begin
                        len_q[t] = p;
                        p = 0;
                        mode_q[t] = MODE_PLAY;
                    end
                    pos_q[t] = p;
                end else if (mode_q[t] == MODE_PLAY && len_q[t] > 0) begin
                    p = pos_q[t];
                    raw = (p < BUFFER_FRAMES) ? int'(loop_mem[t][p]) : 0;
                    s = floor_shr(raw * int'(gain_q[t]), 8);
                    ml += floor_shr(s * (4095 - int'(bal_q[t])), 12);
                    mr += floor_shr(s * int'(bal_q[t]), 12);
                    p++;
                    if (p >= len_q[t]) p = 0;
                    pos_q[t] = p;
                end
            end
            if (mon_q) begin
                ml += mono;
                mr += mono;
            end
            if (ml > 32767) ml = 32767; else if (ml < -32768) ml = -32768;
            if (mr > 32767) mr = 32767; else if (mr < -32768) mr = -32768;
        end else begin
            t = it.track;
            case (it.opcode)
                OP_ACTION:
                    case (mode_q[t])
                        MODE_EMPTY:
                            if (synced) mode_q[t] = MODE_ARMED;
                            else start_take(t, synced, it.quarter_period);
                        MODE_ARMED: mode_q[t] = MODE_EMPTY;
                        MODE_REC:
                        begin
                            len_q[t] = pos_q[t];
                            pos_q[t] = 0;
                            mode_q[t] = MODE_PLAY;
                        end
                        MODE_PLAY: mode_q[t] = MODE_STOP;
                        default:
                        begin
                            len_q[t] = 0;
                            pos_q[t] = 0;
                            if (synced) mode_q[t] = MODE_ARMED;
                            else start_take(t, synced, it.quarter_period);
                        end
                    endcase
                OP_CLEAR:
                begin
                    mode_q[t] = MODE_EMPTY;
                    len_q[t] = 0;
                    pos_q[t] = 0;
                    target_q[t] = 0;
                end
                OP_TOGGLE:
                    if (mode_q[t] == MODE_PLAY) mode_q[t] = MODE_STOP;
                    else if (len_q[t] > 0) begin
                        pos_q[t] = 0;
                        mode_q[t] = MODE_PLAY;
                    end
                OP_LEVEL:
                begin
                    gain_q[t] = it.level;
                    bal_q[t] = it.pan;
                end
                default: ;
            endcase
        end
        r.left_out = 16'(ml);
        r.right_out = 16'(mr);
        r.track_state = mode_q[it.track];
        r.track_length = 17'(len_q[it.track]);
        return r;
    endfunction

    task automatic send_item(input in_item_t it);
        if (!idle_off && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_ch.data <= it;
        in_ch.valid <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        pending_results.push_back(predict_mix(it));
        @(negedge clk);
    endtask

    function automatic in_item_t rand_item();
        in_item_t it;
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        it = bits[$bits(in_item_t)-1:0];
        it.opcode = 3'($urandom_range(0, 7));
        return it;
    endfunction

    function automatic in_item_t frame_item(input int l, input int r, input bit e, input bit lk,
                                            input int unsigned qp);
        in_item_t it;
        it = rand_item();
        it.opcode = OP_FRAME;
        it.left_in = 16'(l);
        it.right_in = 16'(r);
        it.bar_pulse = e;
        it.clock_locked = lk;
        it.quarter_period = 17'(qp);
        return it;
    endfunction

    function automatic in_item_t cmd_item(input logic [2:0] op, input int t, input bit lk);
        in_item_t it;
        it = rand_item();
        it.opcode = op;
        it.track = 2'(t);
        it.clock_locked = lk;
        return it;
    endfunction

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 5'(v);
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SYNC: sync_q = v[0];
            CFG_BARS: bars_q = v & 31;
            default: mon_q = v[0];
        endcase
    endtask

    task automatic test_directed();
        in_item_t it;
        send_item(cmd_item(OP_ACTION, 0, 1'b0));
        send_item(frame_item(32767, 32767, 0, 0, 0));
        send_item(frame_item(-32768, -32768, 0, 0, 0));
        send_item(frame_item(-1, 0, 0, 0, 0));
        send_item(frame_item(1, 0, 0, 0, 0));
        send_item(cmd_item(OP_ACTION, 0, 1'b0));
        it = cmd_item(OP_LEVEL, 0, 1'b0);
        it.level = 8'd255;
        it.pan = 12'd0;
        send_item(it);
        send_item(frame_item(0, 0, 0, 0, 0));
        it.pan = 12'd4095;
        send_item(it);
        send_item(frame_item(0, 0, 1, 1, 0));
        send_item(frame_item(0, 0, 0, 0, 0));
        send_item(cmd_item(OP_ACTION, 1, 1'b1));
        send_item(frame_item(100, -100, 1, 1, 1));
        send_item(frame_item(7, 8, 0, 1, 1));
        send_item(cmd_item(OP_ACTION, 2, 1'b0));
        send_item(cmd_item(OP_ACTION, 2, 1'b0));
        send_item(cmd_item(OP_TOGGLE, 0, 1'b0));
        send_item(cmd_item(OP_TOGGLE, 0, 1'b0));
        send_item(cmd_item(OP_ACTION, 0, 1'b0));
        send_item(cmd_item(OP_CLEAR, 0, 1'b0));
        send_item(cmd_item(3'd5, 1, 1'b0));
        send_item(cmd_item(3'd7, 3, 1'b0));
        drain();
    endtask

    // mostly short takes when synced, with random content, plus noise commands
    task automatic test_random(input int count);
        in_item_t it;
        int k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) < 7) begin
                it = frame_item(int'($urandom) % 32768 * (($urandom & 1) ? 1 : -1),
                                $urandom_range(0, 65535) - 32768,
                                $urandom_range(0, 7) == 0, $urandom_range(0, 3) != 0,
                                $urandom_range(0, 9) == 0 ? $urandom_range(0, 131071)
                                                          : $urandom_range(0, 3));
                if ($urandom_range(0, 30) == 0) it.left_in = 16'sh7fff;
            end else begin
                it = cmd_item(3'($urandom_range(1, 4)), $urandom_range(0, 3),
                              $urandom_range(0, 1));
                if ($urandom_range(0, 20) == 0) it.opcode = 3'($urandom_range(5, 7));
                if (it.opcode == OP_ACTION && $urandom_range(0, 3) == 0)
                    it.quarter_period = 17'($urandom_range(0, 131071));
            end
            send_item(it);
        end
        drain();
    endtask

    task automatic test_backpressure();
        int k;
        hold_cycles = 300;
        for (k = 0; k < 20; k++) send_item(frame_item(k * 50, -k, 0, 0, 0));
        drain();
    endtask

    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, out_ch.data);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (out_ch.data.left_out !== exp_r.left_out) begin
                    $display("%0t: left_out expected %0d actual %0d", $time,
                             exp_r.left_out, out_ch.data.left_out);
                    errors++;
                end
                if (out_ch.data.right_out !== exp_r.right_out) begin
                    $display("%0t: right_out expected %0d actual %0d", $time,
                             exp_r.right_out, out_ch.data.right_out);
                    errors++;
                end
                if (out_ch.data.track_state !== exp_r.track_state) begin
                    $display("%0t: track_state expected %0d actual %0d", $time,
                             exp_r.track_state, out_ch.data.track_state);
                    errors++;
                end
                if (out_ch.data.track_length !== exp_r.track_length) begin
                    $display("%0t: track_length expected %0d actual %0d", $time,
                             exp_r.track_length, out_ch.data.track_length);
                    errors++;
                end
            end
        end
    end

    // receiver: random stall bursts, one long hold on request
    initial
    begin
        int n;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                out_ch.ready <= 1'b0;
                n = hold_cycles;
                hold_cycles = 0;
                repeat (n) @(negedge clk);
                out_ch.ready <= 1'b1;
            end else if (!idle_off && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge clk);
            end else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        int t;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        for (t = 0; t < TRACK_COUNT; t++) begin
            mode_q[t] = MODE_EMPTY;
            len_q[t] = 0;
            pos_q[t] = 0;
            target_q[t] = 0;
            gain_q[t] = 255;
            bal_q[t] = 2048;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        write_reg(CFG_MON, 1);
        test_directed();
        write_reg(CFG_BARS, 0);
        test_random(500);
        test_backpressure();
        write_reg(CFG_SYNC, 0);
        write_reg(CFG_MON, 0);
        test_random(500);
        write_reg(CFG_SYNC, 1);
        write_reg(CFG_BARS, 16);
        write_reg(CFG_MON, 1);
        test_random(400);
        write_reg(CFG_BARS, 1);
        idle_off = 1'b1;
        test_random(450);
        if (errors == 0)
            $display("multitrack_audio_looper test passed");
        else
            $display("multitrack_audio_looper test failed");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("multitrack_audio_looper test failed");
        $finish;
    end
endmodule
